### rtl/rswb_pkg.sv
// Shared constants, codes and types for the remembered-set write barrier.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package rswb_pkg;
	localparam int ADDR_W           = 48;
	localparam int HASH_ENTRIES_DEF = 8192;
	localparam int PROBE_LIMIT_DEF  = 32;
	localparam int CAPACITY         = 8192;
	localparam int IDX_W            = $clog2(CAPACITY);
	localparam int CNT_W            = $clog2(CAPACITY + 1);
	localparam int OP_W             = 2;
	localparam int STS_W            = 4;
	localparam int CFG_IDX_W        = 3;
	localparam int HASH_SHIFT       = 3;

	localparam logic [OP_W-1:0] OP_BARRIER = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	localparam logic [STS_W-1:0] STS_IGNORED     = 4'd0;
	localparam logic [STS_W-1:0] STS_INSERTED    = 4'd1;
	localparam logic [STS_W-1:0] STS_APPENDED    = 4'd2;
	localparam logic [STS_W-1:0] STS_DUPLICATE   = 4'd3;
	localparam logic [STS_W-1:0] STS_VAL_CLEARED = 4'd4;
	localparam logic [STS_W-1:0] STS_NO_MATCH    = 4'd5;
	localparam logic [STS_W-1:0] STS_FULL        = 4'd6;
	localparam logic [STS_W-1:0] STS_SET_CLEARED = 4'd7;
	localparam logic [STS_W-1:0] STS_READ_OK     = 4'd8;
	localparam logic [STS_W-1:0] STS_READ_OOR    = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_COLLECTING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YOUNG_BEGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YOUNG_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_BEGIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OLD_BEGIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OLD_END     = 3'd5;

	typedef struct packed {
		logic              collecting;
		logic [ADDR_W-1:0] young_begin;
		logic [ADDR_W-1:0] young_end;
		logic [ADDR_W-1:0] init_begin;
		logic [ADDR_W-1:0] old_begin;
		logic [ADDR_W-1:0] old_end;
	} rswb_cfg_t;
endpackage

### rtl/rswb_if.sv
// Valid/ready channel interfaces: barrier items, results, register writes.
// Depends on rswb_pkg.
`timescale 1ns / 1ps
interface rswb_item_if import rswb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ADDR_W-1:0] slot_addr;
	logic [ADDR_W-1:0] new_value;
	logic [IDX_W-1:0]  read_index;
	modport source (output valid, operation, slot_addr, new_value, read_index, input ready);
	modport sink (input valid, operation, slot_addr, new_value, read_index, output ready);
endinterface

interface rswb_result_if import rswb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STS_W-1:0]  status;
	logic [CNT_W-1:0]  entry_count;
	logic [ADDR_W-1:0] read_slot;
	logic [ADDR_W-1:0] read_value;
	modport source (output valid, status, entry_count, read_slot, read_value, input ready);
	modport sink (input valid, status, entry_count, read_slot, read_value, output ready);
endinterface

interface rswb_cfg_if import rswb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/rswb_regs.sv
// Configuration register file: region bounds and the collecting flag.
// Depends on rswb_pkg and rswb_cfg_if.
`timescale 1ns / 1ps
module rswb_regs import rswb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rswb_cfg_if.sink   cfg,
	output rswb_cfg_t  regs
);
	rswb_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COLLECTING:  regs_q.collecting  <= cfg.data[0];
				REG_YOUNG_BEGIN: regs_q.young_begin <= cfg.data;
				REG_YOUNG_END:   regs_q.young_end   <= cfg.data;
				REG_INIT_BEGIN:  regs_q.init_begin  <= cfg.data;
				REG_OLD_BEGIN:   regs_q.old_begin   <= cfg.data;
				REG_OLD_END:     regs_q.old_end     <= cfg.data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end
endmodule

### rtl/remembered_set_write_barrier.sv
// Remembered-set write barrier: hash table, slot/value buffers, sequencer.
// Depends on rswb_pkg, rswb_if and rswb_regs.
`timescale 1ns / 1ps
// One result beat per item, in order. The block works on one item at a time;
// the result register lets the next item be accepted while a result waits.
// A young pointer store probes the hash memory, each probe a read (S_PRQ)
// then a check (S_PRC), up to PROBE_LIMIT probes. A duplicate key or a
// null/old store scans the slot buffer entry by entry (S_SCQ, S_SCC) up to
// the current count, through the single read port of the buffer memory.
// After reset the hash memory is swept clear with item ready low; register
// writes are always taken.
// Hash slots hold a valid bit beside the key, so key zero is an ordinary key.
module remembered_set_write_barrier import rswb_pkg::*; #(
	parameter int HASH_ENTRIES = HASH_ENTRIES_DEF,
	parameter int PROBE_LIMIT  = PROBE_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rswb_item_if.sink     item_in,
	rswb_result_if.source result_out,
	rswb_cfg_if.sink      cfg
);
	localparam int HIDX_W = $clog2(HASH_ENTRIES);
	localparam int PRB_W  = $clog2(PROBE_LIMIT + 1);
	localparam logic [PRB_W-1:0]  PRB_LAST  = PRB_W'(PROBE_LIMIT - 1);
	localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HASH_ENTRIES - 1);
	localparam logic [CNT_W-1:0]  CNT_CAP   = CNT_W'(CAPACITY);

	// sequencer states
	localparam logic [3:0] S_CLR  = 4'd0; // hash sweep
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2; // classify item
	localparam logic [3:0] S_PRQ  = 4'd3; // hash read issued
	localparam logic [3:0] S_PRC  = 4'd4; // hash probe check
	localparam logic [3:0] S_SCQ  = 4'd5; // buffer read issued
	localparam logic [3:0] S_SCC  = 4'd6; // buffer compare
	localparam logic [3:0] S_RD   = 4'd7; // read data back
	localparam logic [3:0] S_PUSH = 4'd8; // hand result to output register

	rswb_cfg_t regs;
	rswb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	logic [3:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] nv_q;
	logic [IDX_W-1:0]  ridx_q;
	logic [ADDR_W-1:0] key_q;
	logic [ADDR_W-1:0] val_q;
	logic [HIDX_W-1:0] hidx_q;
	logic [PRB_W-1:0]  probe_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic              scan_clear_q; // 1: null/old store, 0: duplicate update
	logic [HIDX_W-1:0] clr_idx_q;
	logic              clr_push_q;   // sweep came from a clear item
	logic [CNT_W-1:0]  count_q;
	logic [STS_W-1:0]  res_status_q;
	logic [ADDR_W-1:0] res_slot_q;
	logic [ADDR_W-1:0] res_val_q;
	logic              out_valid_q;
	logic [STS_W-1:0]  out_status_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [ADDR_W-1:0] out_slot_q;
	logic [ADDR_W-1:0] out_val_q;

	// memories
	logic [ADDR_W:0]   hash_mem [HASH_ENTRIES];
	logic [ADDR_W-1:0] slot_mem [CAPACITY];
	logic [ADDR_W-1:0] val_mem  [CAPACITY];
	logic [ADDR_W:0]   hash_rd;
	logic [ADDR_W-1:0] slot_rd;
	logic [ADDR_W-1:0] val_rd;

	logic              hash_we;
	logic [HIDX_W-1:0] hash_waddr;
	logic [ADDR_W:0]   hash_wdata;
	logic              append;
	logic              val_we;
	logic [IDX_W-1:0]  buf_waddr;
	logic [IDX_W-1:0]  buf_raddr;

	logic slot_young, nv_young, slot_old, slot_init;
	logic hash_hit, hash_empty, scan_match, scan_last, push_load;
	logic [ADDR_W-1:0] tag_key;

	assign slot_young = (slot_q >= regs.young_begin) && (slot_q < regs.young_end);
	assign nv_young   = (nv_q >= regs.young_begin) && (nv_q < regs.young_end);
	assign slot_old   = (slot_q >= regs.old_begin) && (slot_q < regs.old_end);
	assign slot_init  = (slot_q >= regs.init_begin) && (slot_q < regs.young_begin);
	assign tag_key    = slot_q | ADDR_W'(1);

	assign hash_empty = !hash_rd[ADDR_W];
	assign hash_hit   = hash_rd[ADDR_W] && (hash_rd[ADDR_W-1:0] == key_q);
	assign scan_match = (slot_rd == key_q);
	assign scan_last  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		hash_we    = (state_q == S_CLR) || ((state_q == S_PRC) && hash_empty);
		hash_waddr = (state_q == S_CLR) ? clr_idx_q : hidx_q;
		hash_wdata = (state_q == S_CLR) ? '0 : {1'b1, key_q};
		append     = (state_q == S_PRC) &&
		             (hash_empty || (!hash_hit && (probe_q == PRB_LAST)));
		val_we     = append || ((state_q == S_SCC) && scan_match);
		buf_waddr  = append ? count_q[IDX_W-1:0] : scan_idx_q;
		buf_raddr  = (state_q == S_DEC) ? ridx_q : scan_idx_q;
	end

	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_waddr] <= hash_wdata;
		end
		hash_rd <= hash_mem[hidx_q];
	end

	always_ff @(posedge clk) begin
		if (append) begin
			slot_mem[buf_waddr] <= key_q;
		end
		if (val_we) begin
			val_mem[buf_waddr] <= val_q;
		end
		slot_rd <= slot_mem[buf_raddr];
		val_rd  <= val_mem[buf_raddr];
	end

	assign item_in.ready = (state_q == S_IDLE);
	assign push_load     = (state_q == S_PUSH) && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			op_q         <= OP_BARRIER;
			slot_q       <= '0;
			nv_q         <= '0;
			ridx_q       <= '0;
			key_q        <= '0;
			val_q        <= '0;
			hidx_q       <= '0;
			probe_q      <= '0;
			scan_idx_q   <= '0;
			scan_clear_q <= 1'b0;
			clr_idx_q    <= '0;
			clr_push_q   <= 1'b0;
			count_q      <= '0;
			res_status_q <= STS_IGNORED;
			res_slot_q   <= '0;
			res_val_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + HIDX_W'(1);
					if (clr_idx_q == HIDX_LAST) begin
						if (clr_push_q) begin
							res_status_q <= STS_SET_CLEARED;
							state_q      <= S_PUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (item_in.valid) begin
						op_q    <= item_in.operation;
						slot_q  <= item_in.slot_addr;
						nv_q    <= item_in.new_value;
						ridx_q  <= item_in.read_index;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_slot_q <= '0;
					res_val_q  <= '0;
					unique case (op_q)
						OP_BARRIER: begin
							if (regs.collecting || slot_young || !(slot_old || slot_init)) begin
								res_status_q <= STS_IGNORED;
								state_q      <= S_PUSH;
							end else if ((nv_q == '0) || !nv_young) begin
								key_q        <= tag_key;
								val_q        <= '0;
								scan_clear_q <= 1'b1;
								scan_idx_q   <= '0;
								if (count_q == '0) begin
									res_status_q <= STS_NO_MATCH;
									state_q      <= S_PUSH;
								end else begin
									state_q <= S_SCQ;
								end
							end else if (count_q >= CNT_CAP) begin
								res_status_q <= STS_FULL;
								state_q      <= S_PUSH;
							end else begin
								key_q   <= tag_key;
								val_q   <= nv_q;
								hidx_q  <= tag_key[HASH_SHIFT +: HIDX_W];
								probe_q <= '0;
								state_q <= S_PRQ;
							end
						end
						OP_ADD: begin
							if (regs.collecting) begin
								res_status_q <= STS_IGNORED;
								state_q      <= S_PUSH;
							end else if (count_q >= CNT_CAP) begin
								res_status_q <= STS_FULL;
								state_q      <= S_PUSH;
							end else begin
								key_q   <= slot_q;
								val_q   <= '0;
								hidx_q  <= slot_q[HASH_SHIFT +: HIDX_W];
								probe_q <= '0;
								state_q <= S_PRQ;
							end
						end
						OP_CLEAR: begin
							count_q    <= '0;
							clr_idx_q  <= '0;
							clr_push_q <= 1'b1;
							state_q    <= S_CLR;
						end
						OP_READ: begin
							// buffer read is issued at ridx_q this cycle
							if (CNT_W'(ridx_q) < count_q) begin
								state_q <= S_RD;
							end else begin
								res_status_q <= STS_READ_OOR;
								state_q      <= S_PUSH;
							end
						end
						default: state_q <= S_PUSH;
					endcase
				end
				S_PRQ: state_q <= S_PRC;
				S_PRC: begin
					if (hash_hit) begin
						// duplicate: update first buffered entry, status is 3 either way
						scan_clear_q <= 1'b0;
						scan_idx_q   <= '0;
						if (count_q == '0) begin
							res_status_q <= STS_DUPLICATE;
							state_q      <= S_PUSH;
						end else begin
							state_q <= S_SCQ;
						end
					end else if (hash_empty) begin
						count_q      <= count_q + CNT_W'(1);
						res_status_q <= STS_INSERTED;
						state_q      <= S_PUSH;
					end else if (probe_q == PRB_LAST) begin
						count_q      <= count_q + CNT_W'(1);
						res_status_q <= STS_APPENDED;
						state_q      <= S_PUSH;
					end else begin
						probe_q <= probe_q + PRB_W'(1);
						hidx_q  <= hidx_q + HIDX_W'(1);
						state_q <= S_PRQ;
					end
				end
				S_SCQ: state_q <= S_SCC;
				S_SCC: begin
					if (scan_match) begin
						res_status_q <= scan_clear_q ? STS_VAL_CLEARED : STS_DUPLICATE;
						state_q      <= S_PUSH;
					end else if (scan_last) begin
						res_status_q <= scan_clear_q ? STS_NO_MATCH : STS_DUPLICATE;
						state_q      <= S_PUSH;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
						state_q    <= S_SCQ;
					end
				end
				S_RD: begin
					res_slot_q   <= slot_rd;
					res_val_q    <= val_rd;
					res_status_q <= STS_READ_OK;
					state_q      <= S_PUSH;
				end
				S_PUSH: begin
					if (push_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= STS_IGNORED;
			out_count_q  <= '0;
			out_slot_q   <= '0;
			out_val_q    <= '0;
		end else if (push_load) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
			out_slot_q   <= res_slot_q;
			out_val_q    <= res_val_q;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.status      = out_status_q;
	assign result_out.entry_count = out_count_q;
	assign result_out.read_slot   = out_slot_q;
	assign result_out.read_value  = out_val_q;
endmodule

### rtl/rswb_checker.sv
// Port-level checks on the result channel of the write barrier.
// Depends on rswb_pkg; bound to remembered_set_write_barrier.
`timescale 1ns / 1ps
module rswb_checker import rswb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STS_W-1:0]  status,
	input logic [CNT_W-1:0]  entry_count,
	input logic [ADDR_W-1:0] read_slot,
	input logic [ADDR_W-1:0] read_value
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("stalled result beat changed");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_SET_CLEARED) |-> (entry_count == '0))
		else $error("set cleared but entries remain");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_READ_OK) |-> (read_slot == '0) && (read_value == '0))
		else $error("read data on non-read beat");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == STS_INSERTED) || (status == STS_APPENDED)) |->
		(entry_count != '0))
		else $error("insert reported with empty set");
endmodule

bind remembered_set_write_barrier rswb_checker u_rswb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.status      (result_out.status),
	.entry_count (result_out.entry_count),
	.read_slot   (result_out.read_slot),
	.read_value  (result_out.read_value)
);

### verif/tb.sv
// Self-checking bench for the remembered-set write barrier: directed table, then random and hand-picked phases.
// Depends on rswb_pkg, rswb_if and the remembered_set_write_barrier RTL.
`timescale 1ns / 1ps
module tb;
	import rswb_pkg::*;

	localparam int          HASH_N     = HASH_ENTRIES_DEF;
	localparam int          PROBE_N    = PROBE_LIMIT_DEF;
	localparam longint      CYCLE_CAP  = 4000000;
	localparam logic [47:0] ALL_ONES   = 48'hFFFF_FFFF_FFFF;
	localparam int          PRESS_HOLD = 400;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [CNT_W-1:0]  entry_count;
		logic [ADDR_W-1:0] read_slot;
		logic [ADDR_W-1:0] read_value;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// One directed row. For ROW_REG, slot holds the register index and nv the data.
	typedef struct {
		row_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] slot;
		logic [ADDR_W-1:0] nv;
		logic [IDX_W-1:0]  ridx;
		bit                known;
		outcome_t          want;
	} row_t;

	logic clk;
	logic arst_n;

	rswb_item_if   item_bus ();
	rswb_result_if res_bus ();
	rswb_cfg_if    cfg_bus ();

	remembered_set_write_barrier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_bus),
		.result_out(res_bus),
		.cfg       (cfg_bus)
	);

	// ---------------- shadow of the block ----------------
	logic              sh_collecting;
	logic [ADDR_W-1:0] sh_yb, sh_ye, sh_ib, sh_ob, sh_oe;
	logic [ADDR_W-1:0] hash_key_sh [HASH_N];
	bit                hash_used_sh [HASH_N];
	logic [ADDR_W-1:0] slot_sh [CAPACITY];
	logic [ADDR_W-1:0] value_sh [CAPACITY];
	int unsigned       entries_sh;

	outcome_t pending_q[$];

	int  errors;
	int  items_sent;
	int  results_seen;
	int  clears_sent;
	bit  idle_on;
	bit  press_req;
	longint cycles;

	function automatic bit is_young(input logic [ADDR_W-1:0] a);
		return a >= sh_yb && a < sh_ye;
	endfunction

	function automatic void wipe_set();
		entries_sh = 0;
		for (int i = 0; i < HASH_N; i++) begin
			hash_used_sh[i] = 0;
			hash_key_sh[i]  = '0;
		end
	endfunction

	// First buffer entry with this key gets the value; reports a hit.
	function automatic bit set_first(input logic [ADDR_W-1:0] key, input logic [ADDR_W-1:0] val);
		for (int i = 0; i < entries_sh; i++) begin
			if (slot_sh[i] == key) begin
				value_sh[i] = val;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void push_entry(input logic [ADDR_W-1:0] key, input logic [ADDR_W-1:0] val);
		slot_sh[entries_sh]  = key;
		value_sh[entries_sh] = val;
		entries_sh++;
	endfunction

	// Linear probe over the key hash; appends unhashed when every probe misses.
	function automatic logic [STS_W-1:0] remember_pair(input logic [ADDR_W-1:0] key,
			input logic [ADDR_W-1:0] val);
		int unsigned base;
		int unsigned idx;
		if (entries_sh >= CAPACITY) return STS_FULL;
		base = (key >> HASH_SHIFT) & (HASH_N - 1);
		for (int p = 0; p < PROBE_N; p++) begin
			idx = (base + p) & (HASH_N - 1);
			if (hash_used_sh[idx] && hash_key_sh[idx] == key) begin
				void'(set_first(key, val));
				return STS_DUPLICATE;
			end
			if (!hash_used_sh[idx]) begin
				hash_used_sh[idx] = 1;
				hash_key_sh[idx]  = key;
				push_entry(key, val);
				return STS_INSERTED;
			end
		end
		push_entry(key, val);
		return STS_APPENDED;
	endfunction

	function automatic outcome_t barrier_outcome(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] slot, input logic [ADDR_W-1:0] nv,
			input logic [IDX_W-1:0] ridx);
		outcome_t o;
		logic [ADDR_W-1:0] key;
		bit in_old, in_init;
		o = '0;
		o.status = STS_IGNORED;
		case (op)
			OP_BARRIER: begin
				if (!sh_collecting && !is_young(slot)) begin
					in_old  = slot >= sh_ob && slot < sh_oe;
					in_init = slot >= sh_ib && slot < sh_yb;
					if (in_old || in_init) begin
						key = slot | 48'd1;
						if (nv == '0 || !is_young(nv))
							o.status = set_first(key, '0) ? STS_VAL_CLEARED : STS_NO_MATCH;
						else
							o.status = remember_pair(key, nv);
					end
				end
			end
			OP_ADD: begin
				if (!sh_collecting) o.status = remember_pair(slot, '0);
			end
			OP_CLEAR: begin
				wipe_set();
				o.status = STS_SET_CLEARED;
			end
			default: begin
				if (ridx < entries_sh) begin
					o.status     = STS_READ_OK;
					o.read_slot  = slot_sh[ridx];
					o.read_value = value_sh[ridx];
				end else begin
					o.status = STS_READ_OOR;
				end
			end
		endcase
		o.entry_count = entries_sh[CNT_W-1:0];
		return o;
	endfunction

	// ---------------- clock, reset, watchdog ----------------
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t timeout, %0d results still pending", $time, pending_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------- result side ----------------
	// Random ready bursts; a pressure request holds ready low long enough to back up the input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (press_req) begin
				res_bus.ready <= 1'b0;
				press_req = 0;
				repeat (PRESS_HOLD) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result beat: status %0d count %0d", $time,
					res_bus.status, res_bus.entry_count);
				errors++;
			end else begin
				w = pending_q.pop_front();
				if (res_bus.status !== w.status) begin
					$display("%0t status: expected %0d actual %0d", $time, w.status, res_bus.status);
					errors++;
				end
				if (res_bus.entry_count !== w.entry_count) begin
					$display("%0t entry_count: expected %0d actual %0d", $time,
						w.entry_count, res_bus.entry_count);
					errors++;
				end
				if (res_bus.read_slot !== w.read_slot) begin
					$display("%0t read_slot: expected %h actual %h", $time,
						w.read_slot, res_bus.read_slot);
					errors++;
				end
				if (res_bus.read_value !== w.read_value) begin
					$display("%0t read_value: expected %h actual %h", $time,
						w.read_value, res_bus.read_value);
					errors++;
				end
			end
		end
	end

	// ---------------- drivers ----------------
	// Valid stays high across back-to-back beats; it drops only for a gap or a settle.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] slot,
			input logic [ADDR_W-1:0] nv, input logic [IDX_W-1:0] ridx,
			input bit known, input outcome_t want);
		outcome_t o;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.operation  <= op;
		item_bus.slot_addr  <= slot;
		item_bus.new_value  <= nv;
		item_bus.read_index <= ridx;
		do @(posedge clk); while (!item_bus.ready);
		o = barrier_outcome(op, slot, nv, ridx);
		pending_q.push_back(known ? want : o);
		items_sent++;
		if (op == OP_CLEAR) clears_sent++;
	endtask

	// Drops item valid, waits until every pending result has come back, then idles before touching a register.
	task automatic settle();
		item_bus.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_COLLECTING:  sh_collecting = data[0];
			REG_YOUNG_BEGIN: sh_yb = data;
			REG_YOUNG_END:   sh_ye = data;
			REG_INIT_BEGIN:  sh_ib = data;
			REG_OLD_BEGIN:   sh_ob = data;
			REG_OLD_END:     sh_oe = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_regs(input logic coll, input logic [ADDR_W-1:0] yb,
			input logic [ADDR_W-1:0] ye, input logic [ADDR_W-1:0] ib,
			input logic [ADDR_W-1:0] ob, input logic [ADDR_W-1:0] oe);
		settle();
		write_reg(REG_COLLECTING, {47'd0, coll});
		write_reg(REG_YOUNG_BEGIN, yb);
		write_reg(REG_YOUNG_END, ye);
		write_reg(REG_INIT_BEGIN, ib);
		write_reg(REG_OLD_BEGIN, ob);
		write_reg(REG_OLD_END, oe);
	endtask

	// ---------------- random content ----------------
	function automatic logic [ADDR_W-1:0] rnd48();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ADDR_W-1:0] pick_between(input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] hi);
		logic [63:0] span;
		if (hi <= lo) return rnd48();
		span = hi - lo;
		return lo + ({$urandom, $urandom} % span);
	endfunction

	// Addresses spread over the regions and their edges; some are forced into hash bucket 0 or 1.
	function automatic logic [ADDR_W-1:0] pick_addr();
		logic [ADDR_W-1:0] a;
		case ($urandom_range(0, 9))
			0, 1:    a = pick_between(sh_yb, sh_ye);
			2:       a = pick_between(sh_ib, sh_yb);
			3, 4, 5: a = pick_between(sh_ob, sh_oe);
			6:       a = rnd48();
			7:       a = $urandom_range(0, 1) ? '0 : ALL_ONES;
			default: begin
				case ($urandom_range(0, 5))
					0: a = sh_yb - 1;
					1: a = sh_ye;
					2: a = sh_ye - 1;
					3: a = sh_ob;
					4: a = sh_oe - 1;
					default: a = sh_ib;
				endcase
			end
		endcase
		if ($urandom_range(0, 3) == 0) a[15:3] = $urandom_range(0, 1);
		return a;
	endfunction

	task automatic random_items(input int n);
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] ridx;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60)      op = OP_BARRIER;
			else if (r < 76) op = OP_ADD;
			else if (r < 98) op = OP_READ;
			else             op = OP_CLEAR;
			if ($urandom_range(0, 3) == 0) ridx = $urandom;
			else ridx = (entries_sh + 2 > 8191) ? 13'd8191 : $urandom_range(0, entries_sh + 2);
			send_item(op, pick_addr(), $urandom_range(0, 7) == 0 ? '0 : pick_addr(), ridx,
				0, '0);
			// Keep scans short: the buffer search reads the entries one by one.
			if (entries_sh > 400) send_item(OP_CLEAR, rnd48(), rnd48(), $urandom, 0, '0);
		end
	endtask

	// ---------------- directed table ----------------
	// Typed rows hold outcomes readable on sight; the rest go through the shadow.
	localparam logic [ADDR_W-1:0] D_YB = 48'h0000_1000_0000;
	localparam logic [ADDR_W-1:0] D_YE = 48'h0000_2000_0000;
	localparam logic [ADDR_W-1:0] D_IB = 48'h0000_0800_0000;
	localparam logic [ADDR_W-1:0] D_OB = 48'h0000_8000_0000;
	localparam logic [ADDR_W-1:0] D_OE = 48'h0000_9000_0000;

	row_t plan [] = '{
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd0,    1, '{STS_READ_OOR, 14'd0, '0, '0}},
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd8191, 1, '{STS_READ_OOR, 14'd0, '0, '0}},
		'{ROW_ITEM, OP_BARRIER, '0, '0, 13'd0,    1, '{STS_IGNORED, 14'd0, '0, '0}},
		'{ROW_ITEM, OP_ADD,     '0, '0, 13'd0,    1, '{STS_INSERTED, 14'd1, '0, '0}},
		'{ROW_ITEM, OP_ADD,     '0, '0, 13'd0,    1, '{STS_DUPLICATE, 14'd1, '0, '0}},
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd0,    1, '{STS_READ_OK, 14'd1, '0, '0}},
		'{ROW_ITEM, OP_ADD,     ALL_ONES, ALL_ONES, 13'd0, 1, '{STS_INSERTED, 14'd2, '0, '0}},
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd1,    1, '{STS_READ_OK, 14'd2, ALL_ONES, '0}},
		'{ROW_ITEM, OP_CLEAR,   '0, '0, 13'd0,    1, '{STS_SET_CLEARED, 14'd0, '0, '0}},
		'{ROW_REG,  '0, REG_YOUNG_BEGIN, D_YB, '0, 0, '0},
		'{ROW_REG,  '0, REG_YOUNG_END,   D_YE, '0, 0, '0},
		'{ROW_REG,  '0, REG_INIT_BEGIN,  D_IB, '0, 0, '0},
		'{ROW_REG,  '0, REG_OLD_BEGIN,   D_OB, '0, 0, '0},
		'{ROW_REG,  '0, REG_OLD_END,     D_OE, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8000_0010, 48'h1000_0040, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8000_0010, 48'h1FFF_FFF8, '0, 0, '0},
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8000_0011, '0, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8000_0020, ALL_ONES, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h0800_0008, 48'h1000_0000, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h1000_0000, 48'h1000_0000, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h7FFF_FFFF_FFF0, 48'h1000_0000, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8FFF_FFFF, 48'h1FFF_FFFF, '0, 0, '0},
		'{ROW_ITEM, OP_BARRIER, 48'h8FFF_FFFF, 48'h2000_0000, '0, 0, '0},
		'{ROW_ITEM, OP_ADD,     48'h1234, ALL_ONES, '0, 0, '0},
		'{ROW_ITEM, OP_READ,    '0, '0, 13'd2, 0, '0}
	};

	// ---------------- main sequence ----------------
	initial begin
		arst_n              = 1'b0;
		item_bus.valid      = 1'b0;
		item_bus.operation  = OP_BARRIER;
		item_bus.slot_addr  = '0;
		item_bus.new_value  = '0;
		item_bus.read_index = '0;
		res_bus.ready       = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_COLLECTING;
		cfg_bus.data        = '0;
		errors = 0; items_sent = 0; results_seen = 0; clears_sent = 0;
		idle_on = 1; press_req = 0; cycles = 0;
		sh_collecting = 0;
		sh_yb = '0; sh_ye = '0; sh_ib = '0; sh_ob = '0; sh_oe = '0;
		wipe_set();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].slot[CFG_IDX_W-1:0], plan[i].nv);
			end else begin
				send_item(plan[i].op, plan[i].slot, plan[i].nv, plan[i].ridx,
					plan[i].known, plan[i].want);
			end
		end

		// Layered regions; the result side stalls hard partway through.
		load_regs(0, D_YB, D_YE, D_IB, D_OB, D_OE);
		random_items(70);
		press_req = 1;
		random_items(70);

		// Collection in progress: barriers and adds are dropped.
		load_regs(1, D_YB, D_YE, D_IB, D_OB, D_OE);
		random_items(60);

		// Extremes: old covers everything, young sits at the top of the space.
		load_regs(0, ALL_ONES - 48'h1_0000, ALL_ONES, '0, '0, ALL_ONES);
		random_items(120);

		// Fully random register values.
		load_regs($urandom_range(0, 1), rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
		random_items(100);

		// Hand-picked barriers, an add and a far read, with a clear on either side.
		load_regs(0, D_YB, D_YE, D_IB, D_OB, D_OE);
		send_item(OP_CLEAR, '0, '0, '0, 0, '0);
		send_item(OP_BARRIER, 48'h8000_0100, 48'h1000_0100, '0, 0, '0);
		send_item(OP_ADD, 48'h8, '0, '0, 0, '0);
		send_item(OP_READ, '0, '0, 13'd8191, 0, '0);
		send_item(OP_BARRIER, 48'h8000_0100, '0, '0, 0, '0);
		send_item(OP_CLEAR, '0, '0, '0, 0, '0);

		// Small young window at address zero, tight old window; no idling at the end.
		load_regs(0, '0, 48'h40_0000, '0, 48'h1000_0000, 48'h1010_0000);
		random_items(150);
		idle_on = 0;
		random_items(150);

		item_bus.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d items (%0d clears) across six register settings;",
			items_sent, clears_sent);
		$display("checked %0d result beats, %0d mismatches.", results_seen, errors);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
